// ===== rtl/b8_bitmap_to_sparse_hits_defines.svh =====
// ----------------------------------------------------------------------------
// b8_bitmap_to_sparse_hits_defines.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef B8_BITMAP_TO_SPARSE_HITS_DEFINES_SVH
`define B8_BITMAP_TO_SPARSE_HITS_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define B8_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B8_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/b8bts_pkg.sv =====
// ----------------------------------------------------------------------------
// b8bts_pkg
// Shared constants and types of the bitmap to sparse hit converter.
// ----------------------------------------------------------------------------
package b8bts_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int OBS_CNT_W  = 7;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 16;
   localparam int MASK_W     = 64;
   localparam int KIND_W     = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_RECORD_BITS       = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MEASUREMENT_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DETECTOR_COUNT    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OBSERVABLE_COUNT  = 2'd3;

   localparam logic [CSR_DATA_W-1:0] RECORD_BITS_RST = 17'd8;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_HIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

   // entries between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   // one classified byte
   typedef struct packed {
      logic [BYTE_W-1:0]  hits;     // bits giving a result, error bit highest
      logic               err;      // top set bit of hits is an index error
      logic               rec_end;  // byte closes the record
      logic [INDEX_W-1:0] base;     // low bits of the byte's first bit index
      logic [MASK_W-1:0]  mask;     // observable mask after this byte
   } entry_type;

endpackage

// ===== rtl/b8_bitmap_to_sparse_hits.sv =====
// ----------------------------------------------------------------------------
// b8_bitmap_to_sparse_hits
// Converts packed little-endian bit records, one byte per transaction, into
// a sparse list of detector hit indices, index errors and record ends.
// ----------------------------------------------------------------------------
// The front takes one byte per cycle while the two-entry queue has room,
// classifies its bits and updates record position and observable mask. The
// back delivers one result per cycle while the output is not stalled, through
// a registered output: a byte gives one result for each of its hits, its index
// error and its record end, at most nine in all, and a byte that gives none
// still passes through the back's current-byte register. Register writes reach
// the thresholds through a second register, so no byte is taken while a write
// is presented nor while cfg_wait_ff holds the input off.
module b8_bitmap_to_sparse_hits #(
   parameter int MAX_RECORD_BITS = 65536,
   parameter int MAX_OBSERVABLES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [7:0] data_byte
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [79:0]                            rsp_tdata,   // [15:0] hit_index,
                                                               // [79:16] observable_mask
   output logic [b8bts_pkg::KIND_W-1:0]           rsp_tuser,   // [1:0] kind
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [b8bts_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [b8bts_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import b8bts_pkg::*;

   localparam int BITS_W    = $clog2(MAX_RECORD_BITS + 1);
   localparam int MAX_BYTES = (MAX_RECORD_BITS + 7) / 8;
   localparam int POS_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W     = POS_W + 1;
   localparam int CMP_W     = ((BITS_W > 18) ? BITS_W : 18) + 1;

   logic [CSR_DATA_W-1:0] record_bits_ff, meas_count_ff, det_count_ff;
   logic [OBS_CNT_W-1:0]  obs_count_ff;

   logic [CMP_W-1:0]      bits_ff, bits_in, det_total_ff, det_total_in;
   logic [CMP_W-1:0]      obs_total_ff, obs_total_in, rb_ext, byte_sum;
   logic [CNT_W-1:0]      bytes_ff, bytes_in;
   logic [OBS_CNT_W-1:0]  obs_c;

   logic                  cfg_wait_ff, cfg_hold, front_valid, front_ready;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   entry_type             push_entry, pop_entry;
   logic [INDEX_W-1:0]    rsp_index;
   logic [MASK_W-1:0]     rsp_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_bits_ff <= RECORD_BITS_RST;
         meas_count_ff  <= '0;
         det_count_ff   <= '0;
         obs_count_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RECORD_BITS:       record_bits_ff <= csr_wdata;
            REG_MEASUREMENT_COUNT: meas_count_ff  <= csr_wdata;
            REG_DETECTOR_COUNT:    det_count_ff   <= csr_wdata;
            REG_OBSERVABLE_COUNT:  obs_count_ff   <= csr_wdata[OBS_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the input off until the registered thresholds follow a write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_wait_ff <= 1'b0;
      end else begin
         cfg_wait_ff <= csr_we;
      end
   end

   assign cfg_hold    = csr_we || cfg_wait_ff;
   assign front_valid = req_tvalid && !cfg_hold;
   assign req_tready  = front_ready && !cfg_hold;

   // thresholds from the registers, saturated and registered
   always_comb begin
      rb_ext  = CMP_W'(record_bits_ff);
      bits_in = (rb_ext > CMP_W'(MAX_RECORD_BITS)) ? CMP_W'(MAX_RECORD_BITS) : rb_ext;
      byte_sum = (bits_in + CMP_W'(7)) >> 3;
      bytes_in = (byte_sum == '0) ? CNT_W'(1) : CNT_W'(byte_sum);
      obs_c    = (obs_count_ff > OBS_CNT_W'(MAX_OBSERVABLES)) ?
                 OBS_CNT_W'(MAX_OBSERVABLES) : obs_count_ff;
      det_total_in = CMP_W'(meas_count_ff) + CMP_W'(det_count_ff);
      obs_total_in = det_total_in + CMP_W'(obs_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= CMP_W'(RECORD_BITS_RST);
         bytes_ff     <= CNT_W'(1);
         det_total_ff <= '0;
         obs_total_ff <= '0;
      end else begin
         bits_ff      <= bits_in;
         bytes_ff     <= bytes_in;
         det_total_ff <= det_total_in;
         obs_total_ff <= obs_total_in;
      end
   end

   b8bts_front #(
      .MAX_RECORD_BITS (MAX_RECORD_BITS),
      .MAX_OBSERVABLES (MAX_OBSERVABLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (front_valid),
      .req_tready (front_ready),
      .req_tdata  (req_tdata),
      .bits_c     (bits_ff),
      .det_total  (det_total_ff),
      .obs_total  (obs_total_ff),
      .bytes_c    (bytes_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   b8bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   b8bts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_index  (rsp_index),
      .rsp_mask   (rsp_mask),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {rsp_mask, rsp_index};

endmodule

// ===== rtl/b8bts_queue.sv =====
// ----------------------------------------------------------------------------
// b8bts_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module b8bts_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  b8bts_pkg::entry_type  push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output b8bts_pkg::entry_type  pop_entry
);
   import b8bts_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/b8bts_front.sv =====
// ----------------------------------------------------------------------------
// b8bts_front
// Takes record bytes, tracks position, observable mask and skip flag, and
// classifies each set bit as hit, observable flip or index error.
// ----------------------------------------------------------------------------
module b8bts_front #(
   parameter  int MAX_RECORD_BITS = 65536,
   parameter  int MAX_OBSERVABLES = 64,
   localparam int BITS_W          = $clog2(MAX_RECORD_BITS + 1),
   localparam int MAX_BYTES       = (MAX_RECORD_BITS + 7) / 8,
   localparam int POS_W           = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
   localparam int CNT_W           = POS_W + 1,
   localparam int CMP_W           = ((BITS_W > 18) ? BITS_W : 18) + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [b8bts_pkg::BYTE_W-1:0]        req_tdata,
   input  logic [CMP_W-1:0]                    bits_c,
   input  logic [CMP_W-1:0]                    det_total,
   input  logic [CMP_W-1:0]                    obs_total,
   input  logic [CNT_W-1:0]                    bytes_c,
   output logic                                push_valid,
   input  logic                                push_ready,
   output b8bts_pkg::entry_type                push_entry
);
   import b8bts_pkg::*;

   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [MAX_OBSERVABLES-1:0] mask_ff, mask_in, mask_new, toggle;
   logic                       skip_ff, skip_in;
   logic [CMP_W-1:0]           base;
   logic [CMP_W-1:0]           idx [BYTE_W];
   logic [5:0]                 mpos [BYTE_W];
   logic [5:0]                 off;
   logic [BYTE_W-1:0]          hit_b, flip_b, err_b, err_one;
   logic                       rec_end, take;
   logic [MASK_W-1:0]          mask_wide;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign take       = req_tvalid && push_ready;

   always_comb begin
      base = CMP_W'({pos_ff, 3'b000});
      off  = 6'(base - det_total);
      for (int b = 0; b < BYTE_W; b++) begin
         idx[b]    = base + CMP_W'(b);
         mpos[b]   = off + 6'(b);
         hit_b[b]  = 1'b0;
         flip_b[b] = 1'b0;
         err_b[b]  = 1'b0;
         if (req_tdata[b] && !skip_ff && (idx[b] < bits_c)) begin
            if (idx[b] < det_total) begin
               hit_b[b] = 1'b1;
            end else if (idx[b] < obs_total) begin
               flip_b[b] = 1'b1;
            end else begin
               err_b[b] = 1'b1;
            end
         end
      end
      // only the lowest offending bit counts; the rest of the record is skipped
      err_one = err_b & (~err_b + BYTE_W'(1));

      toggle = '0;
      for (int j = 0; j < MAX_OBSERVABLES; j++) begin
         for (int b = 0; b < BYTE_W; b++) begin
            if (flip_b[b] && (mpos[b] == 6'(j))) begin
               toggle[j] = ~toggle[j];
            end
         end
      end
      mask_new = mask_ff ^ toggle;

      mask_wide = '0;
      mask_wide[MAX_OBSERVABLES-1:0] = mask_new;

      rec_end = ((CNT_W'(pos_ff) + CNT_W'(1)) >= bytes_c);

      pos_in  = rec_end ? '0 : pos_ff + POS_W'(1);
      mask_in = rec_end ? '0 : mask_new;
      skip_in = rec_end ? 1'b0 : (skip_ff || (err_b != '0));

      push_entry.hits    = hit_b | err_one;
      push_entry.err     = (err_b != '0);
      push_entry.rec_end = rec_end;
      push_entry.base    = base[INDEX_W-1:0];
      push_entry.mask    = mask_wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '0;
         skip_ff <= 1'b0;
      end else if (take) begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== rtl/b8bts_back.sv =====
// ----------------------------------------------------------------------------
// b8bts_back
// Walks the result bits of each classified byte lowest first, one result a
// cycle while the output is not stalled, then the record end, into the output register.
// ----------------------------------------------------------------------------
module b8bts_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  b8bts_pkg::entry_type               pop_entry,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [b8bts_pkg::KIND_W-1:0]       rsp_kind,
   output logic [b8bts_pkg::INDEX_W-1:0]      rsp_index,
   output logic [b8bts_pkg::MASK_W-1:0]       rsp_mask,
   output logic                               rsp_tlast
);
   import b8bts_pkg::*;

   logic                cur_valid_ff;
   logic [BYTE_W-1:0]   cur_hits_ff, cur_hits_in;
   logic                cur_err_ff;
   logic                cur_end_ff;
   logic [INDEX_W-1:0]  cur_base_ff;
   logic [MASK_W-1:0]   cur_mask_ff;

   logic                out_valid_ff;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [MASK_W-1:0]   out_mask_ff, out_mask_in;
   logic                out_last_ff;

   logic [BYTE_W-1:0]   low, rest;
   logic [2:0]          low_enc;
   logic                have_hit, emit_hit, emit_end, emit, out_free;
   logic                advance, finish;

   always_comb begin
      have_hit = (cur_hits_ff != '0);
      low      = cur_hits_ff & (~cur_hits_ff + BYTE_W'(1));
      rest     = cur_hits_ff & (cur_hits_ff - BYTE_W'(1));
      low_enc  = '0;
      for (int b = 0; b < BYTE_W; b++) begin
         if (low[b]) begin
            low_enc = low_enc | 3'(b);
         end
      end

      out_free = !out_valid_ff || rsp_tready;
      emit_hit = cur_valid_ff && have_hit;
      emit_end = cur_valid_ff && !have_hit && cur_end_ff;
      emit     = emit_hit || emit_end;
      // a byte with nothing to report still passes through the current-byte register
      advance  = cur_valid_ff && (!emit || out_free);
      finish   = advance && (!have_hit || ((rest == '0) && !cur_end_ff));
      pop_ready = !cur_valid_ff || finish;

      cur_hits_in = rest;

      if (emit_hit) begin
         out_kind_in  = (cur_err_ff && (rest == '0)) ? KIND_ERR : KIND_HIT;
         out_index_in = {cur_base_ff[INDEX_W-1:3], low_enc};
         out_mask_in  = '0;
      end else begin
         out_kind_in  = KIND_END;
         out_index_in = '0;
         out_mask_in  = cur_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         cur_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         cur_hits_ff <= pop_entry.hits;
         cur_err_ff  <= pop_entry.err;
         cur_end_ff  <= pop_entry.rec_end;
         cur_base_ff <= pop_entry.base;
         cur_mask_ff <= pop_entry.mask;
      end else if (advance) begin
         cur_hits_ff <= cur_hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_kind_ff  <= out_kind_in;
         out_index_ff <= out_index_in;
         out_mask_ff  <= out_mask_in;
         out_last_ff  <= emit_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_mask   = out_mask_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/b8bts_checker.sv =====
// ----------------------------------------------------------------------------
// b8bts_checker
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
`include "b8_bitmap_to_sparse_hits_defines.svh"

module b8bts_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [79:0]                       rsp_tdata,
   input  logic [b8bts_pkg::KIND_W-1:0]      rsp_tuser,
   input  logic                              rsp_tlast
);
   import b8bts_pkg::*;

   `B8_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")
   `B8_ASSERT_SAME(a_last_is_end, rsp_tvalid, rsp_tlast == (rsp_tuser == KIND_END), "tlast does not match record end")
   `B8_ASSERT_SAME(a_mask_on_end, rsp_tvalid && (rsp_tuser != KIND_END), rsp_tdata[79:16] == '0, "mask set on a hit or error")
   `B8_ASSERT_SAME(a_end_index, rsp_tvalid && (rsp_tuser == KIND_END), rsp_tdata[15:0] == '0, "index set on record end")

endmodule

bind b8_bitmap_to_sparse_hits b8bts_checker u_checker (.*);
